@@ rtl/uvn_pkg.sv @@
// Package with shared types and constants for the UVN camera update block.
package uvn_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_SLIDE = 2'd0;
    localparam logic [1:0] OP_ROLL  = 2'd1;
    localparam logic [1:0] OP_PITCH = 2'd2;
    localparam logic [1:0] OP_YAW   = 2'd3;

    // Angle arithmetic constants in Q2.30.
    localparam int ANG_FRAC  = 30;
    localparam int TAB_LEN   = 24;
    localparam int SLIDE_FRAC_BITS = 8;
    localparam logic signed [31:0] DEG_TO_RAD_Q30  = 32'sd18740330;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    typedef logic signed [15:0] axis_t;
    typedef logic signed [23:0] eye_t;
    typedef logic signed [33:0] ang_t;

    // Arctangent table in Q2.30, one entry per CORDIC step.
    function automatic ang_t atan_q30(input logic [4:0] idx);
        ang_t r;
        r = '0;
        case (idx)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/uvn_cordic.sv @@
// Iterative rotation-mode CORDIC that turns whole degrees into cosine and sine.
module uvn_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [8:0]   angle_deg,
    output logic                done,
    output uvn_pkg::ang_t       cos_q30,
    output uvn_pkg::ang_t       sin_q30
);
    import uvn_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    logic          busy_reg, busy_next;
    logic [4:0]    step_reg, step_next;
    logic          neg_reg, neg_next;
    ang_t          x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic          done_reg, done_next;
    logic signed [9:0] deg_red;
    logic signed [41:0] z_full;
    ang_t          xs, ys;

    // Fold the angle into [-90,90] and note the sign flip.
    always_comb
    begin
        deg_red = {angle_deg[8], angle_deg};
        neg_next = neg_reg;
        if (start)
        begin
            neg_next = 1'b0;
            if (angle_deg > 9'sd90)
            begin
                deg_red  = {angle_deg[8], angle_deg} - 10'sd180;
                neg_next = 1'b1;
            end
            else if (angle_deg < -9'sd90)
            begin
                deg_red  = {angle_deg[8], angle_deg} + 10'sd180;
                neg_next = 1'b1;
            end
        end
        z_full = deg_red * DEG_TO_RAD_Q30;
    end

    // One micro-rotation per cycle through the shared shifters and adders.
    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = (NSTEP > 0);
            done_next = (NSTEP == 0);
            step_next = '0;
            x_next = ang_t'(CORDIC_GAIN_Q30);
            y_next = '0;
            z_next = ang_t'(z_full);
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q30(step_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q30(step_reg);
            end
            step_next = step_reg + 5'd1;
            if (step_reg == 5'(NSTEP - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    assign done    = done_reg;
    assign cos_q30 = neg_reg ? -x_reg : x_reg;
    assign sin_q30 = neg_reg ? -y_reg : y_reg;

    // The sweep never restarts while it is running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start) else $error("cordic restarted while busy");
    // Done follows the last step or a start.
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) || $past(start)) else $error("stray done");
    // Busy and done are never both set.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg)) else $error("busy with done");

endmodule

@@ rtl/uvn_camera_frame_update.sv @@
// Top level of the UVN camera: state, sequencer and shared multiply-accumulate unit.
// Each transfer on s_axis updates the camera, then one transfer on m_axis returns
// the view matrix. A slide forms the eye update products; a rotation runs the
// CORDIC sweep and then the axis products; every item then forms the
// translation dot products. One 34x24 multiplier with an accumulator does all
// products, one per cycle. s_axis_tready is low from acceptance until the result
// has been taken.
module uvn_camera_frame_update #(
    parameter int AXIS_FRAC_BITS = 14,
    parameter int EYE_FRAC_BITS  = 8,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // opcode[1:0], slide_right[17:2], slide_up[33:18], slide_back[49:34],
    // angle_deg[58:50], zero fill to 64 bits
    input  logic [63:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // right_x, right_y, right_z, up_x, up_y, up_z, back_x, back_y, back_z
    // (16 bits each from bit 0), trans_right[167:144], trans_up[191:168],
    // trans_back[215:192]
    output logic [215:0]  m_axis_tdata
);
    import uvn_pkg::*;

    localparam int SLIDE_SH = SLIDE_FRAC_BITS + AXIS_FRAC_BITS - EYE_FRAC_BITS;
    localparam logic signed [63:0] ONE_RAW = 64'sd1 <<< AXIS_FRAC_BITS;
    localparam logic signed [15:0] ONE_AX =
        (ONE_RAW > 64'sd32767) ? 16'sd32767 : 16'(ONE_RAW);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CORD  = 3'd1;
    localparam logic [2:0] ST_SLIDE = 3'd2;
    localparam logic [2:0] ST_ROT   = 3'd3;
    localparam logic [2:0] ST_TRANS = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;   // term counter inside one sum
    logic [3:0]  sum_reg, sum_next;   // which sum is being formed
    logic [1:0]  op_reg;
    axis_t       d_reg [3];
    axis_t       ax_reg [9];
    axis_t       nax_reg [6];
    eye_t        eye_reg [3];
    logic signed [23:0] tr_reg [3];
    logic signed [63:0] acc_reg;
    logic        cord_start, cord_done;
    logic signed [8:0] ang_reg;
    ang_t        cos_q30, sin_q30;

    logic signed [33:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [57:0] prod;
    logic signed [63:0] acc_sum, rnd;
    logic [3:0]  ia, ib;
    logic        subt;
    logic [3:0]  nterm;

    uvn_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cord_start), .angle_deg(ang_reg),
        .done(cord_done), .cos_q30(cos_q30), .sin_q30(sin_q30)
    );

    // Axis pair chosen by the rotation kind: a is first axis base, b second.
    always_comb
    begin
        ia = 4'd0;
        ib = 4'd3;
        unique case (op_reg)
            OP_ROLL:  begin ia = 4'd0; ib = 4'd3; end
            OP_PITCH: begin ia = 4'd3; ib = 4'd6; end
            OP_YAW:   begin ia = 4'd0; ib = 4'd6; end
            default:  begin ia = 4'd0; ib = 4'd3; end
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        subt  = 1'b0;
        nterm = 4'd3;
        case (state_reg)
            ST_SLIDE:
            begin
                mul_a = 34'(d_reg[cnt_reg[1:0]]);
                mul_b = 24'(ax_reg[4'(cnt_reg * 3) + sum_reg]);
            end
            ST_ROT:
            begin
                // sum_reg 0..2: new a[k]; 3..5: new b[k]; two terms each.
                nterm = 4'd2;
                if (sum_reg < 4'd3)
                begin
                    mul_b = 24'(cnt_reg[0] ? ax_reg[ib + sum_reg] : ax_reg[ia + sum_reg]);
                    mul_a = cnt_reg[0] ? sin_q30 : cos_q30;
                    subt  = cnt_reg[0] && (op_reg != OP_YAW);
                end
                else
                begin
                    mul_b = 24'(cnt_reg[0] ? ax_reg[ia + sum_reg - 4'd3]
                                           : ax_reg[ib + sum_reg - 4'd3]);
                    mul_a = cnt_reg[0] ? sin_q30 : cos_q30;
                    subt  = cnt_reg[0] && (op_reg == OP_YAW);
                end
            end
            ST_TRANS:
            begin
                mul_a = 34'(ax_reg[4'(sum_reg * 3) + cnt_reg]);
                mul_b = eye_reg[cnt_reg[1:0]];
            end
            default: ;
        endcase
        prod = mul_a * mul_b;
        acc_sum = subt ? acc_reg - 64'(prod) : acc_reg + 64'(prod);
    end

    function automatic logic signed [63:0] rshift(input logic signed [63:0] v,
                                                   input int s);
        logic signed [63:0] r;
        r = v;
        if (s > 0)
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
        return r;
    endfunction

    function automatic logic signed [63:0] satw(input logic signed [63:0] v,
                                                 input int w);
        logic signed [63:0] hi, r;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        r = v;
        if (v > hi) r = hi;
        else if (v < -hi - 64'sd1) r = -hi - 64'sd1;
        return r;
    endfunction

    assign rnd = acc_sum;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        cord_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                begin
                    cnt_next = '0;
                    sum_next = '0;
                    if (s_axis_tdata[1:0] == OP_SLIDE) state_next = ST_SLIDE;
                    else state_next = ST_CORD;
                end
            ST_CORD:
            begin
                if (cnt_reg == 4'd0) cord_start = 1'b1;
                cnt_next = 4'd1;
                if (cord_done)
                begin
                    state_next = ST_ROT;
                    cnt_next = '0;
                end
            end
            ST_SLIDE, ST_ROT, ST_TRANS:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == nterm - 4'd1)
                begin
                    cnt_next = '0;
                    sum_next = sum_reg + 4'd1;
                    if ((state_reg == ST_ROT && sum_reg == 4'd5) ||
                        (state_reg != ST_ROT && sum_reg == 4'd2))
                    begin
                        sum_next = '0;
                        state_next = (state_reg == ST_TRANS) ? ST_OUT : ST_TRANS;
                    end
                end
            end
            ST_OUT:
                if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            sum_reg <= '0;
            acc_reg <= '0;
            eye_reg[0] <= 24'(satw(64'sd26 <<< EYE_FRAC_BITS, 24));
            eye_reg[1] <= 24'(satw(64'sd2 <<< EYE_FRAC_BITS, 24));
            eye_reg[2] <= 24'(satw(64'sd55 <<< EYE_FRAC_BITS, 24));
            for (int k = 0; k < 9; k++)
                ax_reg[k] <= (k == 0 || k == 4 || k == 8) ? ONE_AX : 16'sd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            // Accumulate, closing each sum on its last term.
            if (state_reg == ST_SLIDE || state_reg == ST_ROT || state_reg == ST_TRANS)
            begin
                if (cnt_reg == nterm - 4'd1)
                begin
                    acc_reg <= '0;
                    if (state_reg == ST_SLIDE)
                        eye_reg[sum_reg[1:0]] <= 24'(satw(64'(eye_reg[sum_reg[1:0]])
                            + rshift(rnd, SLIDE_SH), 24));
                    else if (state_reg == ST_TRANS)
                        tr_reg[sum_reg[1:0]] <= 24'(satw(rshift(-rnd, AXIS_FRAC_BITS), 24));
                    else
                        nax_reg[sum_reg[2:0]] <= 16'(satw(rshift(rnd, ANG_FRAC), 16));
                end
                else
                    acc_reg <= acc_sum;
                // Commit rotated axes once all six are formed.
                if (state_reg == ST_ROT && state_next == ST_TRANS)
                begin
                    for (int k = 0; k < 2; k++)
                    begin
                        ax_reg[ia + 4'(k)] <= nax_reg[k];
                        ax_reg[ib + 4'(k)] <= nax_reg[3 + k];
                    end
                    ax_reg[ia + 4'd2] <= nax_reg[2];
                    ax_reg[ib + 4'd2] <= 16'(satw(rshift(rnd, ANG_FRAC), 16));
                end
            end
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= s_axis_tdata[1:0];
            d_reg[0] <= s_axis_tdata[17:2];
            d_reg[1] <= s_axis_tdata[33:18];
            d_reg[2] <= s_axis_tdata[49:34];
            ang_reg  <= s_axis_tdata[58:50];
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {tr_reg[2], tr_reg[1], tr_reg[0],
                           ax_reg[8], ax_reg[7], ax_reg[6], ax_reg[5], ax_reg[4],
                           ax_reg[3], ax_reg[2], ax_reg[1], ax_reg[0]};

    // A result appears only after the dot products are done.
    a_out_after_trans: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_TRANS) else $error("early result");
    // No item is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while busy");
    // The rotation path only runs after a CORDIC sweep.
    a_rot_after_cord: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROT) && $changed(state_reg) |-> $past(cord_done))
        else $error("rotation without angle");

endmodule
